FILE: hw/rtl/hte_pkg.sv
// Shared types, entity patterns and replacements for the HTML text extractor.
`timescale 1ns / 1ps
package hte_pkg;

  localparam int NUM_STAGES = 8;
  localparam int PAT_MAX    = 7;
  localparam int REP_MAX    = 3;
  localparam int HOLD_DEPTH = 7;

  localparam logic [7:0] AMP = 8'h26;

  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    logic       last;
  } hte_item_t;

  localparam logic [7:0] PAT [NUM_STAGES][PAT_MAX] = '{
    '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00},
    '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h6D, 8'h64, 8'h61, 8'h73, 8'h68, 8'h3B},
    '{8'h26, 8'h6E, 8'h64, 8'h61, 8'h73, 8'h68, 8'h3B}
  };

  localparam logic [2:0] PAT_LEN [NUM_STAGES] = '{
    3'd6, 3'd5, 3'd4, 3'd4, 3'd6, 3'd5, 3'd7, 3'd7
  };

  localparam logic [7:0] REP [NUM_STAGES][REP_MAX] = '{
    '{8'h20, 8'h00, 8'h00},
    '{8'h26, 8'h00, 8'h00},
    '{8'h3C, 8'h00, 8'h00},
    '{8'h3E, 8'h00, 8'h00},
    '{8'h22, 8'h00, 8'h00},
    '{8'h27, 8'h00, 8'h00},
    '{8'hE2, 8'h80, 8'h94},
    '{8'hE2, 8'h80, 8'h93}
  };

  localparam logic [2:0] REP_LEN [NUM_STAGES] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3
  };

endpackage

FILE: hw/rtl/hte_filter.sv
// Tag, script and style filter feeding the entity cells.
`timescale 1ns / 1ps
module hte_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output hte_pkg::hte_item_t out_item
);

  localparam logic [63:0] END_SCRIPT = "</script";
  localparam logic [55:0] END_STYLE  = "</style";
  localparam logic [47:0] BEG_SCRIPT = "<scrip";
  localparam logic [39:0] BEG_STYLE  = "<styl";

  logic [63:0] win;
  logic tag_open, script_open, style_open;
  logic tag_next, script_next, style_next;
  logic emit;
  logic [7:0] emit_byte;
  logic load;
  hte_pkg::hte_item_t item_q;
  logic valid_q;

  assign in_ready = !valid_q || out_ready;
  assign load = in_valid && in_ready;

  always_comb begin
    tag_next = tag_open;
    script_next = script_open;
    style_next = style_open;
    emit = 1'b0;
    emit_byte = in_byte;
    if (in_byte == 8'h3C) begin
      tag_next = 1'b1;
    end else if (in_byte == 8'h3E) begin
      tag_next = 1'b0;
      if (win == END_SCRIPT) begin
        script_next = 1'b0;
      end else if (win[55:0] == END_STYLE) begin
        style_next = 1'b0;
      end
      emit = 1'b1;
      emit_byte = 8'h20;
    end else begin
      if (win[47:0] == BEG_SCRIPT && in_byte == 8'h74) begin
        script_next = 1'b1;
      end else if (win[39:0] == BEG_STYLE && in_byte == 8'h65) begin
        style_next = 1'b1;
      end
      emit = !tag_open && !script_next && !style_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      tag_open <= 1'b0;
      script_open <= 1'b0;
      style_open <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        if (in_last) begin
          win <= '0;
          tag_open <= 1'b0;
          script_open <= 1'b0;
          style_open <= 1'b0;
        end else begin
          win <= {win[55:0], in_byte};
          tag_open <= tag_next;
          script_open <= script_next;
          style_open <= style_next;
        end
        valid_q <= emit || in_last;
      end else if (out_ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q.data <= emit ? emit_byte : 8'h00;
      item_q.bv <= emit;
      item_q.last <= in_last;
    end
  end

  assign out_valid = valid_q;
  assign out_item = item_q;

endmodule

FILE: hw/rtl/hte_cell.sv
// One find-and-replace cell: holds a partial entity match and a short release queue.
`timescale 1ns / 1ps
module hte_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hte_pkg::hte_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output hte_pkg::hte_item_t out_item
);

  localparam int DEPTH = hte_pkg::HOLD_DEPTH;
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0] hold [DEPTH];
  logic [CW-1:0] cnt;
  logic marker, lastf;
  logic [2:0] prog;

  logic [7:0] ent [DEPTH];
  logic hit, done;
  logic [2:0] prog_inc, newp, prog_next;
  logic [CW-1:0] n;
  logic load, pop;

  assign prog_inc = prog + 3'd1;
  assign hit = in_item.bv && (in_item.data == hte_pkg::PAT[STAGE][prog]);
  assign done = hit && (prog_inc == hte_pkg::PAT_LEN[STAGE]);

  always_comb begin
    if (!in_item.bv) begin
      newp = prog;
      n = in_item.last ? CW'(prog) : '0;
    end else if (done) begin
      newp = '0;
      n = CW'(hte_pkg::REP_LEN[STAGE]);
    end else if (hit) begin
      newp = prog_inc;
      n = in_item.last ? CW'(prog_inc) : '0;
    end else if (in_item.data == hte_pkg::AMP) begin
      newp = 3'd1;
      n = in_item.last ? CW'(prog_inc) : CW'(prog);
    end else begin
      newp = '0;
      n = CW'(prog_inc);
    end
    prog_next = in_item.last ? 3'd0 : newp;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (done) begin
        ent[i] = (i < hte_pkg::REP_MAX) ? hte_pkg::REP[STAGE][i] : 8'h00;
      end else if (i < int'(prog) || hit) begin
        ent[i] = hte_pkg::PAT[STAGE][i];
      end else begin
        ent[i] = in_item.data;
      end
    end
  end

  assign out_valid = (cnt != '0);
  assign pop = out_valid && out_ready;
  assign in_ready = (cnt == '0) || (cnt == CW'(1) && out_ready);
  assign load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      prog <= '0;
      marker <= 1'b0;
      lastf <= 1'b0;
    end else if (load) begin
      prog <= prog_next;
      marker <= (n == '0);
      lastf <= in_item.last;
      cnt <= (n == '0 && in_item.last) ? CW'(1) : n;
    end else if (pop) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < DEPTH; i++) begin
        hold[i] <= ent[i];
      end
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        hold[i] <= hold[i + 1];
      end
    end
  end

  assign out_item.data = hold[0];
  assign out_item.bv = !marker;
  assign out_item.last = lastf && (cnt == CW'(1));

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.bv |-> out_item.last)
    else $error("end marker without last");
  a_prog_range: assert property (@(posedge clk) disable iff (rst)
    prog < hte_pkg::PAT_LEN[STAGE])
    else $error("partial match too long");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load && in_item.last |=> prog == 3'd0)
    else $error("match state kept past last item");

endmodule

FILE: hw/rtl/html_text_extractor_unit.sv
// Top level of the HTML text extractor: filter followed by a chain of entity cells.
//
// Input channel s_axis carries one raw document byte per item, tlast on the
// final byte. Output channel m_axis carries one decoded text byte per item;
// tuser is 1 when tdata holds a byte and 0 on an empty end marker, tlast marks
// the final item of a document. A document that yields no text ends in one
// end marker item.
// The filter takes one byte per cycle while its output is not stalled.
// Each of the eight cells passes one byte per cycle; a cell releasing a held
// partial match or a multi-byte replacement sends it out byte by byte and
// stalls upstream meanwhile.
// Reset clears the tag flags, the byte window and every partial match. When
// m_axis_tready is low, each cell holds its queue and backpressure propagates
// stage by stage to s_axis_tready; no item is dropped.
`timescale 1ns / 1ps
module html_text_extractor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] byte valid
  output logic       m_axis_tlast
);

  localparam int N = hte_pkg::NUM_STAGES;

  logic               v [N+1];
  logic               r [N+1];
  hte_pkg::hte_item_t it [N+1];

  hte_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (v[0]),
    .out_ready (r[0]),
    .out_item  (it[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    hte_cell #(.STAGE(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[g]),
      .in_ready  (r[g]),
      .in_item   (it[g]),
      .out_valid (v[g+1]),
      .out_ready (r[g+1]),
      .out_item  (it[g+1])
    );
  end

  assign r[N] = m_axis_tready;
  assign m_axis_tvalid = v[N];
  assign m_axis_tdata = it[N].data;
  assign m_axis_tuser = it[N].bv;
  assign m_axis_tlast = it[N].last;

endmodule
